### rtl/core/bgauge_pkg.sv
// ----------------------------------------------------------------------------
// bgauge_pkg
// Shared widths, register codes and the fixed lithium-ion discharge curve of
// the battery gauge.
// ----------------------------------------------------------------------------
package bgauge_pkg;

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int MV_W       = 13;
    localparam int PCT_W      = 7;
    localparam int WEIGHT_W   = 16;
    localparam int REF_W      = 12;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int FILT_W     = MV_W + FRAC_W;      // Q13.16 filter value

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_EMA_WEIGHT   = 3'd0;
    localparam cfg_idx_t REG_REFERENCE_MV = 3'd1;
    localparam cfg_idx_t REG_DIVIDER_GAIN = 3'd2;
    localparam cfg_idx_t REG_MAX_MV       = 3'd3;
    localparam cfg_idx_t REG_MIN_MV       = 3'd4;

    localparam logic [WEIGHT_W-1:0] RST_EMA_WEIGHT   = 16'd6554;
    localparam logic [REF_W-1:0]    RST_REFERENCE_MV = 12'd2450;
    localparam logic [GAIN_W-1:0]   RST_DIVIDER_GAIN = 16'd29789;
    localparam logic [MV_W-1:0]     RST_MAX_MV       = 13'd4200;
    localparam logic [MV_W-1:0]     RST_MIN_MV       = 13'd3000;

    // serial shift-add multiplier
    localparam int MCAND_W  = FILT_W;               // widest multiplicand
    localparam int MPLIER_W = 16;                   // one multiplier bit per cycle
    localparam int PROD_W   = MCAND_W + MPLIER_W;
    localparam int STEP_W   = 4;

    // voltage scaling: (avg*ref*gain + 4095*8192) / (4095*16384)
    localparam int NUM_W    = 41;
    localparam int QUOT_W   = 16;
    localparam int DREM_W   = 26;
    localparam logic [DREM_W-1:0] SCALE_DIVISOR = 26'd67092480;
    localparam logic [NUM_W-1:0]  SCALE_ROUND   = 41'd33546240;

    // filter rounding
    localparam logic [PROD_W-1:0] RND_HALF_UP   = 45'd32768;
    localparam logic [PROD_W-1:0] RND_HALF_DOWN = 45'd32767;
    localparam logic [FILT_W-1:0] FILT_HALF     = 29'd32768;

    // charge curve
    localparam int CURVE_POINTS = 12;
    localparam int SEG_W        = 4;
    localparam int SPAN_W       = 9;                // widest segment is 300 mV
    localparam int DPCT_W       = 4;                // widest step is 10 %
    localparam int EXT_W        = SPAN_W + FRAC_W;  // offset into a segment
    localparam int PNUM_W       = 30;
    localparam logic [SEG_W-1:0] SEG_LAST = 4'd10;

    localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
        13'd4200, 13'd4150, 13'd4050, 13'd3950, 13'd3850, 13'd3750,
        13'd3700, 13'd3650, 13'd3550, 13'd3450, 13'd3300, 13'd3000};
    localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
        7'd100, 7'd95, 7'd85, 7'd75, 7'd65, 7'd55,
        7'd45, 7'd35, 7'd25, 7'd15, 7'd5, 7'd0};

    localparam logic [MV_W-1:0]  CURVE_TOP_MV    = 13'd4200;
    localparam logic [MV_W-1:0]  CURVE_BOTTOM_MV = 13'd3000;
    localparam logic [PCT_W-1:0] PCT_FULL        = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY       = 7'd0;

    // lower end of a segment in mV
    function automatic logic [MV_W-1:0] seg_lo_mv(input logic [SEG_W-1:0] seg);
        logic [SEG_W-1:0] nxt;
        nxt = seg + 4'd1;
        return CURVE_MV[nxt];
    endfunction

    // percentage at the lower end of a segment
    function automatic logic [PCT_W-1:0] seg_lo_pct(input logic [SEG_W-1:0] seg);
        logic [SEG_W-1:0] nxt;
        nxt = seg + 4'd1;
        return CURVE_PCT[nxt];
    endfunction

    // width of a segment in mV
    function automatic logic [SPAN_W-1:0] seg_span_mv(input logic [SEG_W-1:0] seg);
        logic [SEG_W-1:0] nxt;
        logic [MV_W-1:0]  span;
        nxt  = seg + 4'd1;
        span = CURVE_MV[seg] - CURVE_MV[nxt];
        return span[SPAN_W-1:0];
    endfunction

    // percentage rise across a segment
    function automatic logic [DPCT_W-1:0] seg_step_pct(input logic [SEG_W-1:0] seg);
        logic [SEG_W-1:0] nxt;
        logic [PCT_W-1:0] step;
        nxt  = seg + 4'd1;
        step = CURVE_PCT[seg] - CURVE_PCT[nxt];
        return step[DPCT_W-1:0];
    endfunction

endpackage

### rtl/core/battery_gauge_average_ema_percent_core.sv
// ----------------------------------------------------------------------------
// battery_gauge_average_ema_percent_core
// Battery gauge: window average of converter samples, scaling to mV with
// clamp, Q16 exponential moving average and piecewise-linear charge lookup.
// ----------------------------------------------------------------------------
// Sequence: the beat that closes a window starts the serial multiplier passes
//   (avg*ref, then *gain, and weight*|x-f| once the filter is seeded), the
//   scaling divider and the curve walk, which all come before out_valid.
// Throughput: one sample a cycle inside a window; the closing beat holds
//   in_stall for the length of the sequencer run.
// Reset: rst_n clears the window, the filter and its seed flag, and loads
//   the default register values; no clearing pass.
// ----------------------------------------------------------------------------
module battery_gauge_average_ema_percent_core #(
    parameter int WINDOW_LOG2 = 5
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [bgauge_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bgauge_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    // sample channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [bgauge_pkg::SAMPLE_W-1:0]        sample,

    // result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [bgauge_pkg::SAMPLE_W-1:0]        window_average,
    output logic [bgauge_pkg::MV_W-1:0]            clamped_millivolts,
    output logic [bgauge_pkg::MV_W-1:0]            filtered_millivolts,
    output logic [bgauge_pkg::PCT_W-1:0]           charge_percent
);

    localparam int SAMPLE_W = bgauge_pkg::SAMPLE_W;
    localparam int MV_W     = bgauge_pkg::MV_W;
    localparam int PCT_W    = bgauge_pkg::PCT_W;
    localparam int FRAC_W   = bgauge_pkg::FRAC_W;
    localparam int FILT_W   = bgauge_pkg::FILT_W;
    localparam int MCAND_W  = bgauge_pkg::MCAND_W;
    localparam int MPLIER_W = bgauge_pkg::MPLIER_W;
    localparam int PROD_W   = bgauge_pkg::PROD_W;
    localparam int STEP_W   = bgauge_pkg::STEP_W;
    localparam int NUM_W    = bgauge_pkg::NUM_W;
    localparam int QUOT_W   = bgauge_pkg::QUOT_W;
    localparam int DREM_W   = bgauge_pkg::DREM_W;
    localparam int SEG_W    = bgauge_pkg::SEG_W;
    localparam int SPAN_W   = bgauge_pkg::SPAN_W;
    localparam int DPCT_W   = bgauge_pkg::DPCT_W;
    localparam int EXT_W    = bgauge_pkg::EXT_W;
    localparam int PNUM_W   = bgauge_pkg::PNUM_W;

    // window accumulator sizing
    localparam int SUM_W = SAMPLE_W + WINDOW_LOG2;
    localparam int CNT_W = (WINDOW_LOG2 > 0) ? WINDOW_LOG2 : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << WINDOW_LOG2) - 1);

    // serial step counts
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(MPLIER_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUOT_W - 1);
    localparam logic [STEP_W-1:0] PDIV_LAST = STEP_W'(DPCT_W - 1);

    // avg*ref fits this many bits
    localparam int AR_W = SAMPLE_W + bgauge_pkg::REF_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_AR,       // avg * reference
        S_MUL_G,        // (avg * reference) * gain
        S_DIV_INIT,     // add rounding term, load divider
        S_DIV,          // restoring divide by the scale constant
        S_CLAMP,
        S_EMA_DIFF,     // |x - f| and its sign
        S_MUL_W,        // weight * |x - f|
        S_EMA_RND,
        S_EMA_UPD,
        S_PCT_INIT,     // end stops of the curve
        S_PCT_SEG,      // walk down the segments
        S_PCT_NUM,
        S_PCT_DIV,      // 4-bit divide by segment span
        S_OUT
    } state_t;

    // ---------------------------------------------------------------- control
    state_t                         state_reg,     state_next;
    logic [bgauge_pkg::WEIGHT_W-1:0] weight_reg,   weight_next;
    logic [bgauge_pkg::REF_W-1:0]   ref_mv_reg,    ref_mv_next;
    logic [bgauge_pkg::GAIN_W-1:0]  gain_reg,      gain_next;
    logic [MV_W-1:0]                max_mv_reg,    max_mv_next;
    logic [MV_W-1:0]                min_mv_reg,    min_mv_next;
    logic [SUM_W-1:0]               sum_reg,       sum_next;
    logic [CNT_W-1:0]               cnt_reg,       cnt_next;
    logic [FILT_W-1:0]              filt_reg,      filt_next;
    logic                           seeded_reg,    seeded_next;
    logic [STEP_W-1:0]              step_reg,      step_next;
    logic [SEG_W-1:0]               seg_reg,       seg_next;
    logic                           out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]            wavg_out_reg,  wavg_out_next;
    logic [MV_W-1:0]                cmv_out_reg,   cmv_out_next;
    logic [MV_W-1:0]                fmv_out_reg,   fmv_out_next;
    logic [PCT_W-1:0]               pct_out_reg,   pct_out_next;

    // --------------------------------------------------------------- datapath
    logic [SAMPLE_W-1:0]            avg_reg,       avg_next;
    logic [MV_W-1:0]                clamped_reg,   clamped_next;
    logic [PCT_W-1:0]               pct_reg,       pct_next;
    logic [MCAND_W-1:0]             mcand_reg,     mcand_next;
    logic [MPLIER_W-1:0]            mplier_reg,    mplier_next;
    logic [PROD_W-1:0]              acc_reg,       acc_next;
    logic [DREM_W-1:0]              rem_reg,       rem_next;
    logic [QUOT_W-1:0]              quot_reg,      quot_next;
    logic                           neg_reg,       neg_next;
    logic [FILT_W-1:0]              delta_reg,     delta_next;
    logic [EXT_W-1:0]               ext_reg,       ext_next;
    logic [SPAN_W-1:0]              prem_reg,      prem_next;
    logic [DPCT_W-1:0]              pquot_reg,     pquot_next;

    // ------------------------------------------------------- combinational
    logic                   in_take;
    logic                   out_free;
    logic [SUM_W-1:0]       sum_add;
    logic [MCAND_W:0]       mul_sum;
    logic [PROD_W-1:0]      mul_acc;
    logic [NUM_W-1:0]       scale_num;
    logic [DREM_W:0]        div_sh;
    logic                   div_ge;
    logic [DREM_W:0]        div_diff;
    logic [QUOT_W-1:0]      raw_mv;
    logic [MV_W-1:0]        clamp_val;
    logic [FILT_W-1:0]      x_val;
    logic [PROD_W-1:0]      rnd_sum;
    logic [MV_W-1:0]        fq_mv;
    logic [FRAC_W-1:0]      fq_frac;
    logic [MV_W-1:0]        lo_mv;
    logic [SPAN_W-1:0]      span_mv;
    logic [DPCT_W-1:0]      step_pct;
    logic [FILT_W-1:0]      ext_full;
    logic [EXT_W+DPCT_W-1:0] pprod;
    logic [PNUM_W-1:0]      pnum;
    logic [SPAN_W:0]        pdiv_sh;
    logic                   pdiv_ge;
    logic [SPAN_W:0]        pdiv_diff;
    logic [FILT_W-1:0]      filt_round;

    assign in_stall            = (state_reg != S_IDLE);
    assign out_valid           = out_valid_reg;
    assign window_average      = wavg_out_reg;
    assign clamped_millivolts  = cmv_out_reg;
    assign filtered_millivolts = fmv_out_reg;
    assign charge_percent      = pct_out_reg;

    assign in_take  = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign sum_add  = sum_reg + SUM_W'(sample);

    // shift-add step: add multiplicand into the top half, shift right
    assign mul_sum = {1'b0, acc_reg[PROD_W-1:MPLIER_W]}
                   + (mplier_reg[0] ? {1'b0, mcand_reg} : {(MCAND_W+1){1'b0}});
    assign mul_acc = {mul_sum, acc_reg[MPLIER_W-1:1]};

    // scaling divider, one quotient bit a cycle
    assign scale_num = NUM_W'(acc_reg[NUM_W-2:0]) + bgauge_pkg::SCALE_ROUND;
    assign div_sh    = {rem_reg, quot_reg[QUOT_W-1]};
    assign div_ge    = (div_sh >= {1'b0, bgauge_pkg::SCALE_DIVISOR});
    assign div_diff  = div_sh - {1'b0, bgauge_pkg::SCALE_DIVISOR};

    // clamp: max is checked first, so min above max still yields max on overflow
    assign raw_mv = quot_reg;
    always_comb
    begin
        if (raw_mv > QUOT_W'(max_mv_reg))
            clamp_val = max_mv_reg;
        else if (raw_mv < QUOT_W'(min_mv_reg))
            clamp_val = min_mv_reg;
        else
            clamp_val = raw_mv[MV_W-1:0];
    end

    assign x_val   = {clamped_reg, {FRAC_W{1'b0}}};
    // round half up on the signed step: +32768 upward, +32767 on magnitude downward
    assign rnd_sum = acc_reg + (neg_reg ? bgauge_pkg::RND_HALF_DOWN
                                        : bgauge_pkg::RND_HALF_UP);

    // curve lookup
    assign fq_mv     = filt_reg[FILT_W-1:FRAC_W];
    assign fq_frac   = filt_reg[FRAC_W-1:0];
    assign lo_mv     = bgauge_pkg::seg_lo_mv(seg_reg);
    assign span_mv   = bgauge_pkg::seg_span_mv(seg_reg);
    assign step_pct  = bgauge_pkg::seg_step_pct(seg_reg);
    assign ext_full  = filt_reg - {lo_mv, {FRAC_W{1'b0}}};
    assign pprod     = ext_reg * step_pct;
    // (2*dp*e + span<<16) >> 17, then divide by span for the rounded step
    assign pnum      = PNUM_W'({pprod, 1'b0}) + PNUM_W'({span_mv, {FRAC_W{1'b0}}});
    assign pdiv_sh   = {prem_reg, pquot_reg[DPCT_W-1]};
    assign pdiv_ge   = (pdiv_sh >= {1'b0, span_mv});
    assign pdiv_diff = pdiv_sh - {1'b0, span_mv};

    assign filt_round = filt_reg + bgauge_pkg::FILT_HALF;

    // ------------------------------------------------------- next state
    always_comb
    begin
        state_next     = state_reg;
        weight_next    = weight_reg;
        ref_mv_next    = ref_mv_reg;
        gain_next      = gain_reg;
        max_mv_next    = max_mv_reg;
        min_mv_next    = min_mv_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        filt_next      = filt_reg;
        seeded_next    = seeded_reg;
        step_next      = step_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg;
        wavg_out_next  = wavg_out_reg;
        cmv_out_next   = cmv_out_reg;
        fmv_out_next   = fmv_out_reg;
        pct_out_next   = pct_out_reg;
        avg_next       = avg_reg;
        clamped_next   = clamped_reg;
        pct_next       = pct_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        neg_next       = neg_reg;
        delta_next     = delta_reg;
        ext_next       = ext_reg;
        prem_next      = prem_reg;
        pquot_next     = pquot_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bgauge_pkg::REG_EMA_WEIGHT:   weight_next = cfg_wdata;
                bgauge_pkg::REG_REFERENCE_MV: ref_mv_next = cfg_wdata[bgauge_pkg::REF_W-1:0];
                bgauge_pkg::REG_DIVIDER_GAIN: gain_next   = cfg_wdata;
                bgauge_pkg::REG_MAX_MV:       max_mv_next = cfg_wdata[MV_W-1:0];
                bgauge_pkg::REG_MIN_MV:       min_mv_next = cfg_wdata[MV_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (cnt_reg == CNT_LAST)
                    begin
                        sum_next    = '0;
                        cnt_next    = '0;
                        avg_next    = sum_add[WINDOW_LOG2 +: SAMPLE_W];
                        mcand_next  = MCAND_W'(sum_add[WINDOW_LOG2 +: SAMPLE_W]);
                        mplier_next = MPLIER_W'(ref_mv_reg);
                        acc_next    = '0;
                        step_next   = '0;
                        state_next  = S_MUL_AR;
                    end
                    else
                    begin
                        sum_next = sum_add;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            S_MUL_AR, S_MUL_G, S_MUL_W:
            begin
                acc_next    = mul_acc;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg + 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    if (state_reg == S_MUL_AR)
                    begin
                        mcand_next  = MCAND_W'(mul_acc[AR_W-1:0]);
                        mplier_next = gain_reg;
                        acc_next    = '0;
                        state_next  = S_MUL_G;
                    end
                    else if (state_reg == S_MUL_G)
                        state_next = S_DIV_INIT;
                    else
                        state_next = S_EMA_RND;
                end
            end

            S_DIV_INIT:
            begin
                rem_next   = DREM_W'(scale_num[NUM_W-1:QUOT_W]);
                quot_next  = scale_num[QUOT_W-1:0];
                step_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                rem_next  = div_ge ? div_diff[DREM_W-1:0] : div_sh[DREM_W-1:0];
                quot_next = {quot_reg[QUOT_W-2:0], div_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                    state_next = S_CLAMP;
            end

            S_CLAMP:
            begin
                clamped_next = clamp_val;
                if (!seeded_reg)
                begin
                    // first window loads the filter directly
                    filt_next   = {clamp_val, {FRAC_W{1'b0}}};
                    seeded_next = 1'b1;
                    state_next  = S_PCT_INIT;
                end
                else
                    state_next = S_EMA_DIFF;
            end

            S_EMA_DIFF:
            begin
                // f' = f + w*(x - f)/2^16, worked on the magnitude
                neg_next    = (filt_reg > x_val);
                mcand_next  = (filt_reg > x_val) ? (filt_reg - x_val) : (x_val - filt_reg);
                mplier_next = weight_reg;
                acc_next    = '0;
                step_next   = '0;
                state_next  = S_MUL_W;
            end

            S_EMA_RND:
            begin
                delta_next = rnd_sum[PROD_W-1:FRAC_W];
                state_next = S_EMA_UPD;
            end

            S_EMA_UPD:
            begin
                filt_next  = neg_reg ? (filt_reg - delta_reg) : (filt_reg + delta_reg);
                state_next = S_PCT_INIT;
            end

            S_PCT_INIT:
            begin
                seg_next = '0;
                if (fq_mv >= bgauge_pkg::CURVE_TOP_MV)
                begin
                    pct_next   = bgauge_pkg::PCT_FULL;
                    state_next = S_OUT;
                end
                else if ((fq_mv < bgauge_pkg::CURVE_BOTTOM_MV) ||
                         ((fq_mv == bgauge_pkg::CURVE_BOTTOM_MV) && (fq_frac == '0)))
                begin
                    pct_next   = bgauge_pkg::PCT_EMPTY;
                    state_next = S_OUT;
                end
                else
                    state_next = S_PCT_SEG;
            end

            S_PCT_SEG:
            begin
                // bottom segment always hits, the walk stops there at the latest
                if ((fq_mv >= lo_mv) || (seg_reg == bgauge_pkg::SEG_LAST))
                begin
                    ext_next   = ext_full[EXT_W-1:0];
                    state_next = S_PCT_NUM;
                end
                else
                    seg_next = seg_reg + 1'b1;
            end

            S_PCT_NUM:
            begin
                prem_next  = pnum[PNUM_W-1 -: SPAN_W];
                pquot_next = pnum[PNUM_W-SPAN_W-1 -: DPCT_W];
                step_next  = '0;
                state_next = S_PCT_DIV;
            end

            S_PCT_DIV:
            begin
                prem_next  = pdiv_ge ? pdiv_diff[SPAN_W-1:0] : pdiv_sh[SPAN_W-1:0];
                pquot_next = {pquot_reg[DPCT_W-2:0], pdiv_ge};
                step_next  = step_reg + 1'b1;
                if (step_reg == PDIV_LAST)
                begin
                    pct_next   = bgauge_pkg::seg_lo_pct(seg_reg)
                               + PCT_W'({pquot_reg[DPCT_W-2:0], pdiv_ge});
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    wavg_out_next  = avg_reg;
                    cmv_out_next   = clamped_reg;
                    fmv_out_next   = filt_round[FILT_W-1:FRAC_W];
                    pct_out_next   = pct_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            weight_reg    <= bgauge_pkg::RST_EMA_WEIGHT;
            ref_mv_reg    <= bgauge_pkg::RST_REFERENCE_MV;
            gain_reg      <= bgauge_pkg::RST_DIVIDER_GAIN;
            max_mv_reg    <= bgauge_pkg::RST_MAX_MV;
            min_mv_reg    <= bgauge_pkg::RST_MIN_MV;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            filt_reg      <= '0;
            seeded_reg    <= 1'b0;
            step_reg      <= '0;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
            wavg_out_reg  <= '0;
            cmv_out_reg   <= '0;
            fmv_out_reg   <= '0;
            pct_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            weight_reg    <= weight_next;
            ref_mv_reg    <= ref_mv_next;
            gain_reg      <= gain_next;
            max_mv_reg    <= max_mv_next;
            min_mv_reg    <= min_mv_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            filt_reg      <= filt_next;
            seeded_reg    <= seeded_next;
            step_reg      <= step_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
            wavg_out_reg  <= wavg_out_next;
            cmv_out_reg   <= cmv_out_next;
            fmv_out_reg   <= fmv_out_next;
            pct_out_reg   <= pct_out_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        avg_reg     <= avg_next;
        clamped_reg <= clamped_next;
        pct_reg     <= pct_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        neg_reg     <= neg_next;
        delta_reg   <= delta_next;
        ext_reg     <= ext_next;
        prem_reg    <= prem_next;
        pquot_reg   <= pquot_next;
    end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the battery gauge core. Windows of converter
// samples go in under several register sets and idle mixes; every result
// beat is checked field by field against a bit-true gauge predictor or a typed-in expectation.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import bgauge_pkg::*;

    localparam int WINDOW_LOG2    = 5;
    localparam int WINDOW         = 1 << WINDOW_LOG2;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 100;    // above the worst-case sequencer run
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no beat on either side
    localparam int MAX_REPORTS    = 10;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_WINDOWS  = 4;
    localparam int TAIL_SAMPLES   = 7;      // partial window left at the end
    localparam int SOC_POINTS     = 12;

    // discharge curve, top to bottom
    localparam int unsigned SOC_MV [SOC_POINTS] = '{
        4200, 4150, 4050, 3950, 3850, 3750, 3700, 3650, 3550, 3450, 3300, 3000};
    localparam int unsigned SOC_PCT [SOC_POINTS] = '{
        100, 95, 85, 75, 65, 55, 45, 35, 25, 15, 5, 0};

    typedef struct packed {
        logic [SAMPLE_W-1:0] avg;
        logic [MV_W-1:0]     clamped;
        logic [MV_W-1:0]     filtered;
        logic [PCT_W-1:0]    pct;
    } gauge_result_t;

    // one directed window: optional register set, then WINDOW samples that
    // alternate between two values
    typedef struct packed {
        logic                  load;
        logic [CFG_DATA_W-1:0] weight;
        logic [CFG_DATA_W-1:0] vref;
        logic [CFG_DATA_W-1:0] gain;
        logic [CFG_DATA_W-1:0] vmax;
        logic [CFG_DATA_W-1:0] vmin;
        logic [SAMPLE_W-1:0]   even_smp;
        logic [SAMPLE_W-1:0]   odd_smp;
        logic                  typed;
        gauge_result_t         want;
    } dir_row_t;

    localparam int DIR_ROWS = 11;

    dir_row_t dir_table [DIR_ROWS] = '{
        // first window after reset seeds the filter straight away
        '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd0,
          1'b1, '{12'd0, 13'd3000, 13'd3000, 7'd0}},
        // zero reference: scaled value is 0, clamped up to min; filter holds
        '{1'b1, 16'd6554, 16'd0, 16'd29789, 16'd4200, 16'd3000, 12'd4095, 12'd4095,
          1'b1, '{12'd4095, 13'd3000, 13'd3000, 7'd0}},
        // defaults back, full-scale input hits the upper clamp
        '{1'b1, 16'd6554, 16'd2450, 16'd29789, 16'd4200, 16'd3000, 12'd4095, 12'd4095,
          1'b0, '0},
        // zero gain
        '{1'b1, 16'd6554, 16'd2450, 16'd0, 16'd4200, 16'd3000, 12'hAAA, 12'h555,
          1'b0, '0},
        // all ones written but to min: bits above each register width must be dropped
        '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 12'd4095, 12'd4095,
          1'b0, '0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd0,
          1'b0, '0},
        // zero weight: the filter must not move
        '{1'b1, 16'd0, 16'd2450, 16'd29789, 16'd4200, 16'd3000, 12'h800, 12'h7FF,
          1'b0, '0},
        // min above max: above max gives max, anything else gives min
        '{1'b1, 16'd32768, 16'd2450, 16'd29789, 16'd3500, 16'd4000, 12'd4095, 12'd4095,
          1'b0, '0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'h555, 12'h555,
          1'b0, '0},
        // sum of 16 ones over the window truncates to an average of 0
        '{1'b1, 16'd6554, 16'd2450, 16'd29789, 16'd4200, 16'd3000, 12'd0, 12'd1,
          1'b0, '0},
        // middle of the curve
        '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'hC00, 12'hC00,
          1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // DUT connections; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    cfg_idx_t              cfg_index  = REG_EMA_WEIGHT;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample     = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [SAMPLE_W-1:0]   window_average;
    logic [MV_W-1:0]       clamped_millivolts;
    logic [MV_W-1:0]       filtered_millivolts;
    logic [PCT_W-1:0]      charge_percent;

    // typed-in expectation travels with the input beat, like a sideband
    logic                  beat_typed = 1'b0;
    gauge_result_t         beat_want  = '0;

    battery_gauge_average_ema_percent_core #(
        .WINDOW_LOG2 (WINDOW_LOG2)
    ) i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .sample              (sample),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .window_average      (window_average),
        .clamped_millivolts  (clamped_millivolts),
        .filtered_millivolts (filtered_millivolts),
        .charge_percent      (charge_percent)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Gauge predictor: own copy of registers and state
    // ------------------------------------------------------------------------
    logic [WEIGHT_W-1:0] cfg_weight = RST_EMA_WEIGHT;
    logic [REF_W-1:0]    cfg_vref   = RST_REFERENCE_MV;
    logic [GAIN_W-1:0]   cfg_gain   = RST_DIVIDER_GAIN;
    logic [MV_W-1:0]     cfg_max    = RST_MAX_MV;
    logic [MV_W-1:0]     cfg_min    = RST_MIN_MV;

    logic [31:0]         win_sum    = '0;
    int                  win_fill   = 0;
    logic [63:0]         ema_q16    = '0;   // Q13.16 mV, kept to 29 bits
    bit                  ema_loaded = 1'b0;

    gauge_result_t       pending_windows [$];

    int gap_pct         = 0;
    int stall_pct       = 0;
    int mismatches      = 0;
    int samples_in      = 0;
    int windows_checked = 0;
    int settings_loaded = 0;
    int idle_cycles     = 0;

    function automatic void gauge_set(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_EMA_WEIGHT:   cfg_weight = d[WEIGHT_W-1:0];
            REG_REFERENCE_MV: cfg_vref   = d[REF_W-1:0];
            REG_DIVIDER_GAIN: cfg_gain   = d[GAIN_W-1:0];
            REG_MAX_MV:       cfg_max    = d[MV_W-1:0];
            REG_MIN_MV:       cfg_min    = d[MV_W-1:0];
            default:          ;     // unmapped index, no effect
        endcase
    endfunction

    // linear interpolation inside the curve segment holding fq, half up
    function automatic logic [PCT_W-1:0] soc_percent(input logic [63:0] fq);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] pct;
        bit          found;
        pct   = '0;
        found = 1'b0;
        if (fq >= (64'(SOC_MV[0]) << FRAC_W))
            pct = 64'd100;
        else if (fq > (64'(SOC_MV[SOC_POINTS-1]) << FRAC_W))
        begin
            for (int k = 0; k < SOC_POINTS - 1; k++)
            begin
                hi = 64'(SOC_MV[k]) << FRAC_W;
                lo = 64'(SOC_MV[k+1]) << FRAC_W;
                if (!found && fq <= hi && fq >= lo)
                begin
                    num   = 64'(SOC_PCT[k] - SOC_PCT[k+1]) * (fq - lo);
                    den   = hi - lo;
                    pct   = 64'(SOC_PCT[k+1]) + (2 * num + den) / (2 * den);
                    found = 1'b1;
                end
            end
        end
        return pct[PCT_W-1:0];
    endfunction

    // one sample in; returns 1 with the result when it closes a window
    function automatic bit gauge_predict(input logic [SAMPLE_W-1:0] smp,
                                         output gauge_result_t res);
        logic [SAMPLE_W-1:0] avg;
        logic [MV_W-1:0]     clamped;
        logic [63:0]         raw;
        logic [63:0]         x;
        logic [63:0]         wt;
        logic [63:0]         rounded;
        res      = '0;
        win_sum  = win_sum + 32'(smp);
        win_fill = win_fill + 1;
        if (win_fill < WINDOW)
            return 1'b0;

        avg      = win_sum[WINDOW_LOG2 +: SAMPLE_W];
        win_sum  = '0;
        win_fill = 0;

        raw = (64'(avg) * 64'(cfg_vref) * 64'(cfg_gain) + 64'd33546240) / 64'd67092480;
        if (raw > 64'(cfg_max))
            clamped = cfg_max;
        else if (raw < 64'(cfg_min))
            clamped = cfg_min;
        else
            clamped = raw[MV_W-1:0];

        x = 64'(clamped) << FRAC_W;
        if (!ema_loaded)
        begin
            ema_q16    = x;
            ema_loaded = 1'b1;
        end
        else
        begin
            wt      = 64'(cfg_weight);
            ema_q16 = (wt * x + (64'd65536 - wt) * ema_q16 + 64'd32768) >> FRAC_W;
        end
        ema_q16 = ema_q16 & 64'h1FFF_FFFF;
        rounded = (ema_q16 + 64'd32768) >> FRAC_W;

        res.avg      = avg;
        res.clamped  = clamped;
        res.filtered = rounded[MV_W-1:0];
        res.pct      = soc_percent(ema_q16);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Beat monitor and checker. Both channels are handled in one process so
    // that an input beat closing a window is always booked before a result
    // beat on the same edge is compared.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : beat_monitor
        gauge_result_t predicted;
        gauge_result_t want;
        gauge_result_t got;
        bit            any_beat;
        if (rst_n)
        begin
            any_beat = 1'b0;
            if (in_valid && !in_stall)
            begin
                any_beat   = 1'b1;
                samples_in = samples_in + 1;
                if (gauge_predict(sample, predicted))
                    pending_windows.push_back(beat_typed ? beat_want : predicted);
            end
            if (out_valid && !out_stall)
            begin
                any_beat     = 1'b1;
                got.avg      = window_average;
                got.clamped  = clamped_millivolts;
                got.filtered = filtered_millivolts;
                got.pct      = charge_percent;
                if (pending_windows.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result beat with no window pending", $realtime);
                end
                else
                begin
                    want            = pending_windows.pop_front();
                    windows_checked = windows_checked + 1;
                    if (got.avg !== want.avg || got.clamped !== want.clamped ||
                        got.filtered !== want.filtered || got.pct !== want.pct)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t: window %0d mismatch (exp/got): avg %0d/%0d",
                                      " clamp %0d/%0d filt %0d/%0d pct %0d/%0d"},
                                     $realtime, windows_checked, want.avg, got.avg,
                                     want.clamped, got.clamped, want.filtered,
                                     got.filtered, want.pct, got.pct);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);

            // watchdog: a long run with no beat means the block has hung
            idle_cycles = any_beat ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat for %0d cycles, %0d windows pending",
                         idle_cycles, pending_windows.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // one sample beat; payload holds steady while stalled
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                               input gauge_result_t typed_res);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        sample     <= s;
        beat_typed <= typed;
        beat_want  <= typed_res;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop sending, let every pending window come out, then give the block
    // its worst-case latency before anything touches the registers; the
    // first edge lets the monitor book the last input beat
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge clk);
        gauge_set(idx, d);
    endtask

    // full register set, plus junk to the unmapped indexes
    task automatic load_settings(input logic [CFG_DATA_W-1:0] w, vr, g, mx, mn);
        reg_write(REG_EMA_WEIGHT, w);
        reg_write(REG_REFERENCE_MV, vr);
        reg_write(REG_DIVIDER_GAIN, g);
        reg_write(REG_MAX_MV, mx);
        reg_write(REG_MIN_MV, mn);
        for (int k = REG_MIN_MV + 1; k < (1 << CFG_IDX_W); k++)
            reg_write(cfg_idx_t'(k), CFG_DATA_W'($urandom));
        cfg_wr_en       <= 1'b0;
        settings_loaded  = settings_loaded + 1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t            row;
        logic [SAMPLE_W-1:0] base;
        int                  spread;
        int                  level;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed windows, no idling
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = dir_table[r];
            if (row.load)
            begin
                drain_block();
                load_settings(row.weight, row.vref, row.gain, row.vmax, row.vmin);
            end
            for (int k = 0; k < WINDOW; k++)
                send_sample((k % 2) ? row.odd_smp : row.even_smp, row.typed, row.want);
        end

        // random windows; each phase drains first, so the sender also sits
        // out until every result is home
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain_block();
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 87; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 87; end
                default: begin gap_pct = 35; stall_pct = 35; end
            endcase

            if (ph == 0)
                load_settings(16'd6554, 16'd2450, 16'd29789, 16'd4200, 16'd3000);
            else if (ph == 1)
                load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else if (ph == 2)
                load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            else if ($urandom_range(1) == 0)
                // a plausible board: readings land across the curve
                load_settings(CFG_DATA_W'($urandom_range(65535)),
                              CFG_DATA_W'($urandom_range(3300, 2000)),
                              CFG_DATA_W'($urandom_range(40000, 20000)),
                              CFG_DATA_W'($urandom_range(8191, 3600)),
                              CFG_DATA_W'($urandom_range(3400, 0)));
            else
                load_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                              CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                              CFG_DATA_W'($urandom));

            for (int wi = 0; wi < PHASE_WINDOWS; wi++)
            begin
                // mostly a steady level with a little noise, near the span
                // that maps onto the charge curve; sometimes pure noise
                base   = ($urandom_range(9) < 8) ? SAMPLE_W'($urandom_range(4095, 2400))
                                                 : SAMPLE_W'($urandom_range(4095));
                spread = ($urandom_range(9) < 7) ? $urandom_range(40) : -1;
                for (int k = 0; k < WINDOW; k++)
                begin
                    if (spread < 0)
                        level = $urandom_range(4095);
                    else
                        level = int'(base) + int'($urandom_range(2 * spread)) - spread;
                    if (level < 0)
                        level = 0;
                    if (level > 4095)
                        level = 4095;
                    send_sample(SAMPLE_W'(level), 1'b0, '0);
                end
            end
        end

        // a window left open at the end must produce nothing
        for (int k = 0; k < TAIL_SAMPLES; k++)
            send_sample(SAMPLE_W'($urandom_range(4095)), 1'b0, '0);

        drain_block();

        $display("Run covered %0d samples and %0d checked windows under %0d register sets,",
                 samples_in, windows_checked, settings_loaded);
        $display("with sender and receiver idling in four mixes; %0d mismatches.", mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
